>>> hw/rtl/spl_pkg.sv
package spl_pkg;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_SHOW   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_NONE   = 2'd3
   } spl_mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } spl_status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SHOW = 1'b1
   } spl_state_type;

   typedef struct packed {
      logic insert;
      logic rotate;
   } spl_cmd_type;

endpackage

>>> hw/rtl/sorted_priority_list.sv
// sorted priority list: holds up to CAPACITY (priority, tag) entries in
// ascending priority order, lower value first, equal priorities newest first.
// request channel: req_valid/req_stall with req_mode, req_priority_req and
// req_task_tag. mode insert adds an entry, show lists all entries, clear
// empties the list. response channel: rsp_valid/rsp_stall with one
// registered transaction per result; rsp_last marks the final one.
// insert, clear and the unused mode give one result, registered, in the
// cycle after acceptance. show gives one result per held entry, one per
// cycle while rsp_stall is low, the first in the cycle after acceptance;
// the entries circulate through the chain of cells and the head cell
// feeds the output. a show holds off new requests until its last entry.
// a full list drops an insert and reports status full.
// while rsp_stall is high with a result pending, the block holds its
// state and raises req_stall.
// reset clears the entry count and any pending result; entry storage
// needs no clearing, so the block accepts transactions right after reset.
module sorted_priority_list #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  spl_pkg::spl_mode_type      req_mode,
   input  logic [PRIORITY_BITS-1:0]   req_priority_req,
   input  logic [TAG_BITS-1:0]        req_task_tag,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [PRIORITY_BITS-1:0]   rsp_entry_priority,
   output logic [TAG_BITS-1:0]        rsp_entry_tag,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_entry_count,
   output spl_pkg::spl_status_type    rsp_status,
   output logic                       rsp_last
);
   import spl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   spl_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PRIORITY_BITS-1:0] rsp_priority_ff, rsp_priority_in;
   logic [TAG_BITS-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   spl_status_type           rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   spl_cmd_type              cmd;
   logic [PRIORITY_BITS-1:0] head_priority;
   logic [TAG_BITS-1:0]      head_tag;
   logic                     out_free;
   logic                     accept;
   logic                     emit;

   spl_chain #(
      .CAPACITY     (CAPACITY),
      .PRIORITY_BITS(PRIORITY_BITS),
      .TAG_BITS     (TAG_BITS),
      .CNT_W        (CNT_W)
   ) u_chain (
      .clock        (clock),
      .cmd          (cmd),
      .count        (count_ff),
      .new_priority (req_priority_req),
      .new_tag      (req_task_tag),
      .head_priority(head_priority),
      .head_tag     (head_tag)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_SHOW) || !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      remain_in       = remain_ff;
      cmd             = '0;
      emit            = 1'b0;
      rsp_priority_in = rsp_priority_ff;
      rsp_tag_in      = rsp_tag_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               emit            = 1'b1;
               rsp_priority_in = '0;
               rsp_tag_in      = '0;
               rsp_status_in   = STATUS_OK;
               rsp_last_in     = 1'b1;
               unique case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_SHOW: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cmd.rotate      = 1'b1;
                        rsp_priority_in = head_priority;
                        rsp_tag_in      = head_tag;
                        remain_in       = count_ff - CNT_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           rsp_last_in = 1'b0;
                           state_in    = ST_SHOW;
                        end
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_SHOW: begin
            if (out_free) begin
               emit            = 1'b1;
               cmd.rotate      = 1'b1;
               rsp_priority_in = head_priority;
               rsp_tag_in      = head_tag;
               rsp_count_in    = count_ff;
               rsp_status_in   = STATUS_OK;
               remain_in       = remain_ff - CNT_W'(1);
               rsp_last_in     = (remain_ff == CNT_W'(1));
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_priority_ff <= rsp_priority_in;
      rsp_tag_ff      <= rsp_tag_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_priority = rsp_priority_ff;
   assign rsp_entry_tag      = rsp_tag_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

>>> hw/rtl/spl_cell.sv
module spl_cell #(
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  logic                     clock,
   input  spl_pkg::spl_cmd_type     cmd,
   input  logic                     occupied,
   input  logic                     tail,
   input  logic [PRIORITY_BITS-1:0] new_priority,
   input  logic [TAG_BITS-1:0]      new_tag,
   input  logic                     prev_lt,
   input  logic [PRIORITY_BITS-1:0] prev_priority,
   input  logic [TAG_BITS-1:0]      prev_tag,
   input  logic [PRIORITY_BITS-1:0] next_priority,
   input  logic [TAG_BITS-1:0]      next_tag,
   input  logic [PRIORITY_BITS-1:0] wrap_priority,
   input  logic [TAG_BITS-1:0]      wrap_tag,
   output logic                     lt,
   output logic [PRIORITY_BITS-1:0] cell_priority,
   output logic [TAG_BITS-1:0]      cell_tag
);
   import spl_pkg::*;

   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;

   assign lt            = occupied && (priority_ff < new_priority);
   assign cell_priority = priority_ff;
   assign cell_tag      = tag_ff;

   always_comb begin
      priority_in = priority_ff;
      tag_in      = tag_ff;
      priority if (cmd.insert) begin
         if (!lt) begin
            if (prev_lt) begin
               priority_in = new_priority;
               tag_in      = new_tag;
            end else begin
               priority_in = prev_priority;
               tag_in      = prev_tag;
            end
         end
      end else if (cmd.rotate) begin
         if (tail) begin
            priority_in = wrap_priority;
            tag_in      = wrap_tag;
         end else begin
            priority_in = next_priority;
            tag_in      = next_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      tag_ff      <= tag_in;
   end

endmodule

>>> hw/rtl/spl_chain.sv
module spl_chain #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16,
   parameter int CNT_W         = 5
) (
   input  logic                     clock,
   input  spl_pkg::spl_cmd_type     cmd,
   input  logic [CNT_W-1:0]         count,
   input  logic [PRIORITY_BITS-1:0] new_priority,
   input  logic [TAG_BITS-1:0]      new_tag,
   output logic [PRIORITY_BITS-1:0] head_priority,
   output logic [TAG_BITS-1:0]      head_tag
);
   import spl_pkg::*;

   logic [PRIORITY_BITS-1:0] pri_w [CAPACITY];
   logic [TAG_BITS-1:0]      tag_w [CAPACITY];
   logic                     lt_w  [CAPACITY];

   assign head_priority = pri_w[0];
   assign head_tag      = tag_w[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     occupied;
      logic                     tail;
      logic                     prev_lt;
      logic [PRIORITY_BITS-1:0] prev_priority, next_priority;
      logic [TAG_BITS-1:0]      prev_tag, next_tag;

      assign occupied = CNT_W'(i) < count;
      assign tail     = CNT_W'(i + 1) == count;

      if (i == 0) begin : g_first
         assign prev_lt       = 1'b1;
         assign prev_priority = new_priority;
         assign prev_tag      = new_tag;
      end else begin : g_mid
         assign prev_lt       = lt_w[i-1];
         assign prev_priority = pri_w[i-1];
         assign prev_tag      = tag_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign next_priority = pri_w[i];
         assign next_tag      = tag_w[i];
      end else begin : g_body
         assign next_priority = pri_w[i+1];
         assign next_tag      = tag_w[i+1];
      end

      spl_cell #(
         .PRIORITY_BITS(PRIORITY_BITS),
         .TAG_BITS     (TAG_BITS)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .occupied     (occupied),
         .tail         (tail),
         .new_priority (new_priority),
         .new_tag      (new_tag),
         .prev_lt      (prev_lt),
         .prev_priority(prev_priority),
         .prev_tag     (prev_tag),
         .next_priority(next_priority),
         .next_tag     (next_tag),
         .wrap_priority(pri_w[0]),
         .wrap_tag     (tag_w[0]),
         .lt           (lt_w[i]),
         .cell_priority(pri_w[i]),
         .cell_tag     (tag_w[i])
      );
   end

endmodule
